### hw/rtl/bba_pkg.sv
package bba_pkg;

	// Word kind on the request channel
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Per-node tree code
	typedef enum logic [1:0] {
		NS_FREE  = 2'd0,
		NS_ALLOC = 2'd1,
		NS_SPLIT = 2'd2,
		NS_FULL  = 2'd3
	} node_st_t;

	// Response status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_TOOBIG  = 2'd2,
		ST_BADFREE = 2'd3
	} rsp_code_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_READ,
		S_EVAL,
		S_SPLIT,
		S_UP,
		S_REFRESH,
		S_DONE
	} fsm_t;

	// Datapath commands
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ROUND,
		OP_RDNODE,
		OP_EVAL,
		OP_SPLIT,
		OP_UP,
		OP_REFRESH,
		OP_FINISH
	} op_t;

	// Outcome of a node visit
	typedef enum logic [1:0] {
		DEC_SPLIT,
		DEC_DOWN,
		DEC_TAKE,
		DEC_RET
	} dec_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic round_done;
		logic oversize;
		dec_t dec;
		logic go_right;
		logic at_root;
		logic out_free;
	} sts_t;

	function automatic logic is_full(node_st_t s);
		return (s == NS_ALLOC) || (s == NS_FULL);
	endfunction

	// Parent code from its two children
	function automatic node_st_t merge_kids(node_st_t l, node_st_t r);
		node_st_t res;
		if (is_full(l) && is_full(r)) begin
			res = NS_FULL;
		end else if ((l == NS_FREE) && (r == NS_FREE)) begin
			res = NS_FREE;
		end else begin
			res = NS_SPLIT;
		end
		return res;
	endfunction

endpackage

### hw/rtl/bba_if.sv
interface bba_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] request_size;
	logic [47:0] address;

	modport source (output valid, output kind, output request_size, output address,
		input ready);
	modport sink (input valid, input kind, input request_size, input address,
		output ready);
endinterface

interface bba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [47:0] block_address;
	logic [16:0] grant_size;
	logic [16:0] used_bytes;

	modport source (output valid, output status, output block_address,
		output grant_size, output used_bytes, input ready);
	modport sink (input valid, input status, input block_address,
		input grant_size, input used_bytes, output ready);
endinterface

### hw/rtl/buddy_block_allocator_top.sv
// Buddy block allocator.
// Requests arrive on the req channel (valid/ready): kind 0 allocates
// request_size bytes, kind 1 frees the block at address. Each request word
// gives exactly one response word on the rsp channel with status, granted
// block address and size, and the bytes in use afterwards.
// cfg_wen/cfg_wdata write pool_base, the address of the first pool byte;
// write it only while no request is in flight.
// One request is worked at a time. The tree of node codes lives in a
// single-write, dual-read store. Each level visited is read and evaluated
// on the way down, with an extra step where a free block is split, and is
// refreshed from its children on the way back up; rounding the request
// size takes one step per doubling. Backtracking into right subtrees
// revisits the levels retried, and a free or a failed request that stops
// near the root visits fewer levels.
// Reset frees the whole pool and clears the byte count; no clearing pass
// is needed. A finished response sits in an output register; if the
// receiver stalls, the next request may still be taken and worked, but its
// response waits until the held word is accepted.
module buddy_block_allocator_top #(
	parameter int MIN_BLOCK_LOG2 = 6,
	parameter int TREE_LEVELS    = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [47:0] cfg_wdata,
	bba_req_if.sink     req,
	bba_rsp_if.source   rsp
);
	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign req.ready = in_ready;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bba_datapath #(
		.MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
		.TREE_LEVELS    (TREE_LEVELS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wen           (cfg_wen),
		.cfg_wdata         (cfg_wdata),
		.in_kind           (req.kind),
		.in_request_size   (req.request_size),
		.in_address        (req.address),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_status        (rsp.status),
		.out_block_address (rsp.block_address),
		.out_block_size    (rsp.grant_size),
		.out_used_bytes    (rsp.used_bytes),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule

### hw/rtl/bba_ctrl.sv
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	fsm_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_ROUND;
			end
			S_ROUND: begin
				if (sts.round_done) state_d = sts.oversize ? S_DONE : S_READ;
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				case (sts.dec)
					DEC_SPLIT: state_d = S_SPLIT;
					DEC_DOWN:  state_d = S_READ;
					default:   state_d = sts.at_root ? S_DONE : S_UP;
				endcase
			end
			S_SPLIT: begin
				state_d = S_READ;
			end
			S_UP: begin
				state_d = S_REFRESH;
			end
			S_REFRESH: begin
				if (sts.go_right) begin
					state_d = S_READ;
				end else begin
					state_d = sts.at_root ? S_DONE : S_UP;
				end
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Drive commands
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_ROUND: begin
				if (!sts.round_done) cmd.op = OP_ROUND;
			end
			S_READ:    cmd.op = OP_RDNODE;
			S_EVAL:    cmd.op = OP_EVAL;
			S_SPLIT:   cmd.op = OP_SPLIT;
			S_UP:      cmd.op = OP_UP;
			S_REFRESH: cmd.op = OP_REFRESH;
			S_DONE: begin
				if (sts.out_free) cmd.op = OP_FINISH;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	// A word is only taken while idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (state_q == S_IDLE) && in_valid)
		else $error("load outside idle");
	// Finishing always returns to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH) |=> (state_q == S_IDLE))
		else $error("finish did not return to idle");
	// A split is always followed by a descent into the left child
	a_split_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |=> (state_q == S_READ))
		else $error("split not followed by read");

endmodule

### hw/rtl/bba_datapath.sv
module bba_datapath #(
	parameter int MIN_BLOCK_LOG2 = 6,
	parameter int TREE_LEVELS    = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [47:0]   cfg_wdata,
	input  logic          in_kind,
	input  logic [31:0]   in_request_size,
	input  logic [47:0]   in_address,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    out_status,
	output logic [47:0]   out_block_address,
	output logic [16:0]   out_block_size,
	output logic [16:0]   out_used_bytes,
	input  bba_pkg::cmd_t cmd,
	output bba_pkg::sts_t sts
);
	import bba_pkg::*;

	localparam int POOL_LOG2  = MIN_BLOCK_LOG2 + TREE_LEVELS - 1;
	localparam int SZ_W       = POOL_LOG2 + 1;
	localparam int NW         = TREE_LEVELS;
	localparam int NODE_COUNT = (2 ** TREE_LEVELS) - 1;
	localparam int LV_W       = $clog2(TREE_LEVELS);
	localparam logic [SZ_W-1:0] POOL_SIZE = SZ_W'(1) << POOL_LOG2;
	localparam logic [LV_W-1:0] LAST_LV   = LV_W'(TREE_LEVELS - 1);

	node_st_t mem [NODE_COUNT];

	logic [47:0]     pool_base_q;
	logic            kind_q;
	logic [31:0]     req_q;
	logic [47:0]     rel_q;
	logic            over_q;
	logic [LV_W-1:0] blvl_q;
	logic [NW-1:0]   n_q;
	logic [LV_W-1:0] level_q;
	logic [SZ_W-1:0] size_q;
	logic [SZ_W-1:0] ofs_q;
	logic            ok_q;
	logic [SZ_W-1:0] got_q;
	logic [SZ_W-1:0] freed_q;
	logic [SZ_W-1:0] used_q;
	logic            came_left_q;
	node_st_t        root_q;
	logic            rd_root_q;
	node_st_t        rd_a_q;
	node_st_t        rd_b_q;
	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [47:0]     baddr_q;
	logic [SZ_W-1:0] bsize_q;
	logic [SZ_W-1:0] ubytes_q;

	logic [SZ_W-1:0] half;
	logic [SZ_W-1:0] blk_size;
	logic [NW-1:0]   kid_l;
	logic [NW-1:0]   kid_r;
	logic [NW-1:0]   sib_l;
	logic [NW-1:0]   parent;
	logic [NW-1:0]   ra;
	logic [NW-1:0]   rb;
	node_st_t        cur_st;
	dec_t            dec;
	logic            free_right;
	logic            we;
	logic [NW-1:0]   waddr;
	node_st_t        wdata;
	logic            out_free;

	// Tree navigation
	assign half     = size_q >> 1;
	assign blk_size = POOL_SIZE >> blvl_q;
	assign kid_l    = {n_q[NW-2:0], 1'b1};
	assign kid_r    = NW'(kid_l + NW'(1));
	assign sib_l    = n_q[0] ? n_q : NW'(n_q - NW'(1));
	assign parent   = NW'((n_q - NW'(1)) >> 1);
	assign cur_st   = rd_root_q ? root_q : rd_a_q;
	assign free_right = (rel_q >= 48'(ofs_q + half));
	assign out_free = !out_valid_q || out_ready;

	// Decide what a visit does
	always_comb begin
		dec = DEC_RET;
		if (kind_q == KIND_ALLOC) begin
			if (cur_st == NS_FREE && blvl_q > level_q) begin
				dec = DEC_SPLIT;
			end else if (cur_st == NS_FREE && blvl_q == level_q) begin
				dec = DEC_TAKE;
			end else if (cur_st == NS_SPLIT && level_q < LAST_LV) begin
				dec = DEC_DOWN;
			end
		end else begin
			if ((cur_st == NS_SPLIT || cur_st == NS_FULL) && level_q < LAST_LV) begin
				dec = DEC_DOWN;
			end else if (cur_st == NS_ALLOC && rel_q == 48'(ofs_q)) begin
				dec = DEC_TAKE;
			end
		end
	end

	always_comb begin
		sts.round_done = (kind_q == KIND_FREE) || over_q ||
			(64'(blk_size) >= 64'(req_q));
		sts.oversize   = over_q && (kind_q == KIND_ALLOC);
		sts.dec        = dec;
		sts.go_right   = (kind_q == KIND_ALLOC) && !ok_q && came_left_q;
		sts.at_root    = (level_q == '0);
		sts.out_free   = out_free;
	end

	// Tree write port
	always_comb begin
		we    = 1'b0;
		waddr = n_q;
		wdata = NS_FREE;
		case (cmd.op)
			OP_EVAL: begin
				if (dec == DEC_SPLIT) begin
					we    = 1'b1;
					waddr = kid_l;
				end else if (dec == DEC_TAKE) begin
					we    = 1'b1;
					wdata = (kind_q == KIND_ALLOC) ? NS_ALLOC : NS_FREE;
				end
			end
			OP_SPLIT: begin
				we    = 1'b1;
				waddr = kid_r;
			end
			OP_REFRESH: begin
				we    = 1'b1;
				wdata = merge_kids(rd_a_q, rd_b_q);
			end
			default: we = 1'b0;
		endcase
	end

	assign ra = (cmd.op == OP_UP) ? sib_l : n_q;
	assign rb = NW'(sib_l + NW'(1));

	// Node store, root kept apart so reset frees it
	always_ff @(posedge clk) begin
		if (we && waddr != '0) mem[waddr] <= wdata;
		rd_a_q    <= mem[ra];
		rd_b_q    <= mem[rb];
		rd_root_q <= (ra == '0);
	end

	// Control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			root_q      <= NS_FREE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) pool_base_q <= cfg_wdata;
			if (we && waddr == '0) root_q <= wdata;
			if (cmd.op == OP_EVAL && dec == DEC_TAKE) begin
				if (kind_q == KIND_ALLOC) begin
					used_q <= SZ_W'(used_q + size_q);
				end else begin
					used_q <= (used_q >= size_q) ? SZ_W'(used_q - size_q) : '0;
				end
			end
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q  <= in_kind;
				req_q   <= in_request_size;
				rel_q   <= in_address - pool_base_q;
				over_q  <= (64'(in_request_size) > 64'(POOL_SIZE));
				blvl_q  <= LAST_LV;
				n_q     <= '0;
				level_q <= '0;
				size_q  <= POOL_SIZE;
				ofs_q   <= '0;
				ok_q    <= 1'b0;
				got_q   <= '0;
				freed_q <= '0;
			end
			OP_ROUND: begin
				blvl_q <= LV_W'(blvl_q - LV_W'(1));
			end
			OP_EVAL: begin
				if (dec == DEC_DOWN) begin
					level_q <= LV_W'(level_q + LV_W'(1));
					size_q  <= half;
					if (kind_q == KIND_FREE && free_right) begin
						n_q   <= kid_r;
						ofs_q <= SZ_W'(ofs_q + half);
					end else begin
						n_q <= kid_l;
					end
				end else if (dec == DEC_TAKE) begin
					ok_q <= 1'b1;
					if (kind_q == KIND_ALLOC) begin
						got_q <= ofs_q;
					end else begin
						freed_q <= size_q;
					end
				end
			end
			OP_SPLIT: begin
				n_q     <= kid_l;
				level_q <= LV_W'(level_q + LV_W'(1));
				size_q  <= half;
			end
			OP_UP: begin
				came_left_q <= n_q[0];
				n_q         <= parent;
				level_q     <= LV_W'(level_q - LV_W'(1));
				size_q      <= SZ_W'(size_q << 1);
				if (!n_q[0]) ofs_q <= SZ_W'(ofs_q - size_q);
			end
			OP_REFRESH: begin
				if (sts.go_right) begin
					n_q     <= kid_r;
					level_q <= LV_W'(level_q + LV_W'(1));
					size_q  <= half;
					ofs_q   <= SZ_W'(ofs_q + half);
				end
			end
			OP_FINISH: begin
				ubytes_q <= used_q;
				if (kind_q == KIND_FREE) begin
					status_q <= ok_q ? ST_OK : ST_BADFREE;
					baddr_q  <= '0;
					bsize_q  <= ok_q ? freed_q : '0;
				end else if (over_q) begin
					status_q <= ST_TOOBIG;
					baddr_q  <= '0;
					bsize_q  <= '0;
				end else begin
					status_q <= ok_q ? ST_OK : ST_NOFIT;
					baddr_q  <= ok_q ? (pool_base_q + 48'(got_q)) : '0;
					bsize_q  <= ok_q ? blk_size : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign out_status        = status_q;
	assign out_block_address = baddr_q;
	assign out_block_size    = 17'(bsize_q);
	assign out_used_bytes    = 17'(ubytes_q);

	// Tree writes stay inside the node store
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (32'(waddr) < NODE_COUNT))
		else $error("node write out of range");
	// Bytes in use never exceed the pool
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= POOL_SIZE)
		else $error("used bytes above pool size");
	// The walk never goes below the leaf level
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EVAL) |-> (level_q <= LAST_LV))
		else $error("walk below leaf level");

endmodule
